[hdl/opr_pkg.sv]
// Shared types and constants for the optimal page replacement simulator.
// No dependencies; imported by opr_frames and optimal_page_replacement_sim.
package opr_pkg;

    // Fixed field widths of the stream payloads
    localparam int PAGE_W     = 16;
    localparam int CFG_W      = 4;
    localparam int SLOT_W     = 3;
    localparam int FAULT_W    = 7;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 48;

    // Command group from the sequencer to the frame table
    typedef struct packed {
        logic clear;       // empty all frames
        logic wr_en;       // load a page into a frame
        logic scan_start;  // forget next-use marks before a scan
        logic scan_en;     // compare one scanned reference against the frames
    } frm_cmd_t;

    // Status group from the frame table to the sequencer
    typedef struct packed {
        logic hit;         // looked-up page is resident
        logic has_empty;   // an active frame is still empty
    } frm_stat_t;

endpackage

[hdl/opr_ref_mem.sv]
// Reference string store: one write port, one read port, registered read data.
// No dependencies.
module opr_ref_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[hdl/opr_frames.sv]
// Page frame table: resident pages, valid bits, parallel compare lanes and
// the next-use tracking that picks a victim. Depends on opr_pkg.
module opr_frames #(
    parameter int MAX_FRAMES = 8,
    parameter int FW         = 3,
    parameter int NFW        = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  opr_pkg::frm_cmd_t        cmd,
    input  logic [NFW-1:0]           nf,
    input  logic [opr_pkg::PAGE_W-1:0] cmp_page,
    input  logic [FW-1:0]            wr_idx,
    input  logic [opr_pkg::PAGE_W-1:0] wr_page,
    output opr_pkg::frm_stat_t       stat,
    output logic [FW-1:0]            empty_idx,
    output logic [FW-1:0]            victim_idx,
    output logic [opr_pkg::PAGE_W-1:0] victim_page
);
    import opr_pkg::*;

    logic [PAGE_W-1:0]     page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [MAX_FRAMES-1:0] found_reg;
    logic [FW-1:0]         last_reg;

    logic [MAX_FRAMES-1:0] act;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] newly;
    logic [FW-1:0]         unf_idx;
    logic                  any_unf;
    logic                  any_empty;
    logic [FW-1:0]         new_idx;

    // per-lane active mask and page compare
    always_comb begin
        for (int f = 0; f < MAX_FRAMES; f++) begin
            act[f]   = (32'(f) < 32'(nf));
            match[f] = (page_reg[f] == cmp_page);
        end
    end

    assign newly = act & match & ~found_reg;

    // priority encoders: lowest empty, lowest never-used-again, first-seen lane
    always_comb begin
        empty_idx = '0;
        any_empty = 1'b0;
        unf_idx   = '0;
        any_unf   = 1'b0;
        new_idx   = '0;
        for (int f = MAX_FRAMES - 1; f >= 0; f--) begin
            if (act[f] && !valid_reg[f]) begin
                empty_idx = FW'(f);
                any_empty = 1'b1;
            end
            if (act[f] && !found_reg[f]) begin
                unf_idx = FW'(f);
                any_unf = 1'b1;
            end
            if (newly[f]) begin
                new_idx = FW'(f);
            end
        end
    end

    assign stat = '{hit: (|(valid_reg & match)), has_empty: any_empty};
    // the lane whose next use was seen last in the scan lies farthest ahead
    assign victim_idx  = any_unf ? unf_idx : last_reg;
    assign victim_page = page_reg[victim_idx];

    // valid and next-use marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            found_reg <= '0;
        end else begin
            if (cmd.clear) begin
                valid_reg <= '0;
            end else if (cmd.wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.scan_start) begin
                found_reg <= '0;
            end else if (cmd.scan_en) begin
                found_reg <= found_reg | (act & match);
            end
        end
    end

    // page payload and latest first-use lane
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            page_reg[wr_idx] <= wr_page;
        end
        if (cmd.scan_en && (|newly)) begin
            last_reg <= new_idx;
        end
    end

endmodule

[hdl/optimal_page_replacement_sim.sv]
// Top level of the optimal (farthest next use) page replacement simulator.
// Depends on opr_pkg, opr_ref_mem and opr_frames.
//
//  channel | ports                        | payload, low bit first
//  --------+------------------------------+----------------------------------------
//  in      | s_tvalid s_tready s_tdata    | page[15:0]; s_tlast = last
//  out     | m_tvalid m_tready m_tdata    | ref_page, slot, evicted_valid,
//          |                              | evicted_page, fault_total; m_tuser =
//          |                              | was_fault; m_tlast = run_end
//  config  | cfg_valid cfg_ready cfg_data | frame_count[3:0]
//
// Loading takes one beat per cycle, only in the load phase. Replay reads,
// evaluates and emits each reference on a hit or on a fill of an empty frame;
// a miss with all frames full adds a scan over the later references through
// the single read port of the reference memory and a victim pick.
// Reset needs no clearing pass. Replay holds while the output register holds an untaken beat.
module optimal_page_replacement_sim #(
    parameter int MAX_FRAMES = 8,
    parameter int REF_DEPTH  = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [opr_pkg::S_TDATA_W-1:0] s_tdata,   // page[15:0]
    input  logic                          s_tlast,
    // result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [opr_pkg::M_TDATA_W-1:0] m_tdata,   // ref_page[15:0], slot[18:16],
                                                     // evicted_valid[19],
                                                     // evicted_page[35:20],
                                                     // fault_total[42:36]
    output logic                          m_tuser,   // was_fault
    output logic                          m_tlast,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [opr_pkg::CFG_W-1:0]     cfg_data   // frame_count[3:0]
);
    import opr_pkg::*;

    localparam int AW  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CW  = $clog2(REF_DEPTH + 1);
    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NFW = $clog2(MAX_FRAMES + 1);
    localparam int PAD_W = M_TDATA_W - (2 * PAGE_W + SLOT_W + 1 + FAULT_W);

    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_READ = 6'b000010,
        ST_EVAL = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_PICK = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               dv_reg, dv_next;
    logic [NFW-1:0]     nf_reg, nf_next;
    logic [CFG_W-1:0]   fcfg_reg;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic [PAGE_W-1:0]  pg_reg, pg_next;
    logic               res_fault_reg, res_fault_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic               res_ev_reg, res_ev_next;
    logic [PAGE_W-1:0]  res_evpage_reg, res_evpage_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;
    logic               m_last_reg, m_last_next;

    logic               in_beat;
    logic               out_free;
    logic               pos_last;
    logic [AW-1:0]      raddr;
    logic [PAGE_W-1:0]  rdata;
    frm_cmd_t           fcmd;
    frm_stat_t          fstat;
    logic [FW-1:0]      wr_idx;
    logic [PAGE_W-1:0]  wr_page;
    logic [FW-1:0]      empty_idx;
    logic [FW-1:0]      victim_idx;
    logic [PAGE_W-1:0]  victim_page;
    logic [NFW-1:0]     nf_clamp;

    assign s_tready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign pos_last  = ((pos_reg + CW'(1)) == cnt_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // frame count sampled at replay start, zero as one, saturate at table size
    always_comb begin
        if (fcfg_reg == '0) begin
            nf_clamp = NFW'(1);
        end else if (32'(fcfg_reg) > MAX_FRAMES) begin
            nf_clamp = NFW'(MAX_FRAMES);
        end else begin
            nf_clamp = NFW'(fcfg_reg);
        end
    end

    // reference memory read address
    always_comb begin
        case (state_reg)
            ST_SCAN: raddr = k_reg[AW-1:0];
            default: raddr = pos_reg[AW-1:0];
        endcase
    end

    opr_ref_mem #(
        .DEPTH  (REF_DEPTH),
        .ADDR_W (AW),
        .DATA_W (PAGE_W)
    ) u_ref_mem (
        .aclk  (aclk),
        .we    (in_beat),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_tdata[PAGE_W-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    opr_frames #(
        .MAX_FRAMES (MAX_FRAMES),
        .FW         (FW),
        .NFW        (NFW)
    ) u_frames (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (fcmd),
        .nf          (nf_reg),
        .cmp_page    (rdata),
        .wr_idx      (wr_idx),
        .wr_page     (wr_page),
        .stat        (fstat),
        .empty_idx   (empty_idx),
        .victim_idx  (victim_idx),
        .victim_page (victim_page)
    );

    // replay sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        dv_next         = dv_reg;
        nf_next         = nf_reg;
        fault_next      = fault_reg;
        pg_next         = pg_reg;
        res_fault_next  = res_fault_reg;
        res_slot_next   = res_slot_reg;
        res_ev_next     = res_ev_reg;
        res_evpage_next = res_evpage_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;
        fcmd            = '0;
        wr_idx          = empty_idx;
        wr_page         = rdata;

        case (state_reg)
            ST_LOAD: begin
                if (in_beat) begin
                    cnt_next = cnt_reg + CW'(1);
                    if (s_tlast || ((cnt_reg + CW'(1)) == CW'(REF_DEPTH))) begin
                        nf_next    = nf_clamp;
                        pos_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                pg_next         = rdata;
                res_fault_next  = 1'b0;
                res_slot_next   = '0;
                res_ev_next     = 1'b0;
                res_evpage_next = '0;
                if (fstat.hit) begin
                    state_next = ST_EMIT;
                end else if (fstat.has_empty) begin
                    fcmd.wr_en     = 1'b1;
                    fault_next     = fault_reg + FAULT_W'(1);
                    res_fault_next = 1'b1;
                    res_slot_next  = SLOT_W'(empty_idx);
                    state_next     = ST_EMIT;
                end else begin
                    fcmd.scan_start = 1'b1;
                    k_next          = pos_reg + CW'(1);
                    dv_next         = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue one read a cycle, compare the beat read last cycle
                fcmd.scan_en = dv_reg;
                if (k_reg < cnt_reg) begin
                    k_next  = k_reg + CW'(1);
                    dv_next = 1'b1;
                end else begin
                    dv_next = 1'b0;
                    if (!dv_reg) begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                fcmd.wr_en      = 1'b1;
                wr_idx          = victim_idx;
                wr_page         = pg_reg;
                fault_next      = fault_reg + FAULT_W'(1);
                res_fault_next  = 1'b1;
                res_slot_next   = SLOT_W'(victim_idx);
                res_ev_next     = 1'b1;
                res_evpage_next = victim_page;
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {{PAD_W{1'b0}}, fault_reg, res_evpage_reg,
                                     res_ev_reg, res_slot_reg, pg_reg};
                    m_user_next   = res_fault_reg;
                    m_last_next   = pos_last;
                    if (pos_last) begin
                        fcmd.clear = 1'b1;
                        cnt_next   = '0;
                        fault_next = '0;
                        pos_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        pos_next   = pos_reg + CW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            k_reg        <= '0;
            dv_reg       <= 1'b0;
            nf_reg       <= NFW'(1);
            fcfg_reg     <= CFG_W'(3);
            fault_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pos_reg      <= pos_next;
            k_reg        <= k_next;
            dv_reg       <= dv_next;
            nf_reg       <= nf_next;
            fault_reg    <= fault_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                fcfg_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pg_reg         <= pg_next;
        res_fault_reg  <= res_fault_next;
        res_slot_reg   <= res_slot_next;
        res_ev_reg     <= res_ev_next;
        res_evpage_reg <= res_evpage_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        m_last_reg     <= m_last_next;
    end

    // checks
    a_load_only_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (cnt_reg < CW'(REF_DEPTH)))
        else $error("input taken with the reference store full");

    a_run_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && pos_last)
        |=> (cnt_reg == '0 && fault_reg == '0 && state_reg == ST_LOAD))
        else $error("run state not cleared after the final result");

    a_hit_no_eviction: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[19:16] == 4'b0000 && m_tdata[35:20] == '0))
        else $error("hit result carries a slot or an eviction");

    a_scan_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && !fstat.hit && !fstat.has_empty) |=> (state_reg == ST_SCAN))
        else $error("full-table miss did not start a scan");

endmodule
